### sv/cpwa_pkg.sv
// ----------------------------------------------------------------------------
// cpwa_pkg: shared types and constants of the cubic warp address generator
// Scaling constants, fixed-point widths, polynomial coefficients and the
// monomial bundle that travels from the monomial stages to the evaluators.
// ----------------------------------------------------------------------------
package cpwa_pkg;

    // Field widths
    localparam int COL_W     = 14;
    localparam int ROW_W     = 12;
    localparam int SRC_W     = 16;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 1;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = 15'd6240;
    localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = 15'd1600;

    // Number of register stages from the input word to the output word
    localparam int NSTG = 11;

    // Coordinate scaling: X = round(col * XS_NUM / XS_DEN) in Q16
    localparam int Q_FRAC = 16;
    localparam int RCP_W  = 32;
    localparam int REM_W  = 15;

    localparam logic [63:0] XS_NUM = 64'd6239;
    localparam logic [63:0] XS_DEN = 64'd10455;
    localparam logic [63:0] YS_NUM = 64'd1599;
    localparam logic [63:0] YS_DEN = 64'd2663;

    // Truncated reciprocals give an estimate that is exact or one low.
    localparam logic [RCP_W-1:0]  X_RCP  = RCP_W'((XS_NUM << (2 * Q_FRAC)) / XS_DEN);
    localparam logic [Q_FRAC-1:0] X_BIAS = Q_FRAC'(((XS_DEN >> 1) << Q_FRAC) / XS_DEN);
    localparam logic [REM_W-1:0]  X_NLO  = REM_W'(XS_DEN >> 1);
    localparam logic [REM_W-1:0]  X_DIV  = REM_W'(XS_DEN);
    localparam logic [RCP_W-1:0]  Y_RCP  = RCP_W'((YS_NUM << (2 * Q_FRAC)) / YS_DEN);
    localparam logic [Q_FRAC-1:0] Y_BIAS = Q_FRAC'(((YS_DEN >> 1) << Q_FRAC) / YS_DEN);
    localparam logic [REM_W-1:0]  Y_NLO  = REM_W'(YS_DEN >> 1);
    localparam logic [REM_W-1:0]  Y_DIV  = REM_W'(YS_DEN);

    // Monomial widths (unsigned Q16)
    localparam int X_W   = COL_W + RCP_W - Q_FRAC;
    localparam int Y_W   = ROW_W + RCP_W - Q_FRAC;
    localparam int XX_W  = 43;
    localparam int XY_W  = 41;
    localparam int YY_W  = 39;
    localparam int X3_W  = 56;
    localparam int X2Y_W = 54;
    localparam int XY2_W = 52;
    localparam int Y3_W  = 50;

    // Coefficient widths (signed Q40) for linear, quadratic and cubic terms
    localparam int LIN_W  = 42;
    localparam int QUAD_W = 27;
    localparam int CUB_W  = 17;

    localparam int ACC_W    = 64;
    localparam int ACC_FRAC = 40;
    localparam int RES_W    = ACC_W - ACC_FRAC;
    localparam logic signed [ACC_W-1:0] ACC_HALF = 64'sh0000_0080_0000_0000;

    typedef logic signed [ACC_W-1:0] coef_arr_t [10];

    // Order: 1, X, Y, X^2, XY, Y^2, X^3, X^2Y, XY^2, Y^3
    localparam coef_arr_t COL_COEF = '{
        64'sd2245642548569702, 64'sd1420239169598, -64'sd30406994066,
        -64'sd4652583, -64'sd12838997, 64'sd20909413,
        64'sd150, 64'sd7909, -64'sd9048, 64'sd3131
    };
    localparam coef_arr_t ROW_COEF = '{
        64'sd955849438490788, -64'sd223750616252, 64'sd1210012546367,
        64'sd63494597, 64'sd22668631, 64'sd48644593,
        -64'sd6394, -64'sd8666, 64'sd20035, -64'sd63100
    };

    typedef struct packed {
        logic [X_W-1:0]   x;
        logic [Y_W-1:0]   y;
        logic [XX_W-1:0]  xx;
        logic [XY_W-1:0]  xy;
        logic [YY_W-1:0]  yy;
        logic [X3_W-1:0]  x3;
        logic [X2Y_W-1:0] x2y;
        logic [XY2_W-1:0] xy2;
        logic [Y3_W-1:0]  y3;
    } mono_t;

endpackage

### sv/cpwa_mul.sv
// ----------------------------------------------------------------------------
// cpwa_mul: two-stage signed multiplier with Q16 round-half-up reduction
// The b operand is split in two halves; the partial products are registered
// and then summed, biased by one half and shifted down by 16 bits.
// ----------------------------------------------------------------------------
module cpwa_mul #(
    parameter int AW = 31,
    parameter int BW = 31,
    parameter int OW = 44
) (
    input  logic                 clk,
    input  logic [1:0]           en,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [OW-1:0] p
);
    import cpwa_pkg::*;

    localparam int LW = BW / 2;
    localparam int HW = BW - LW;
    localparam int PW = AW + BW;
    localparam int SW = PW - Q_FRAC;
    localparam logic signed [PW-1:0] RND = PW'(2 ** (Q_FRAC - 1));

    logic [LW-1:0]             b_lo;
    logic signed [HW-1:0]      b_hi;
    logic signed [AW+LW:0]     plo_next;
    logic signed [AW+LW:0]     plo_reg;
    logic signed [AW+HW-1:0]   phi_next;
    logic signed [AW+HW-1:0]   phi_reg;
    logic signed [PW-1:0]      sum;
    logic signed [SW-1:0]      shifted;
    logic signed [OW-1:0]      p_next;
    logic signed [OW-1:0]      p_reg;

    assign b_lo     = b[LW-1:0];
    assign b_hi     = $signed(b[BW-1:LW]);
    assign plo_next = a * $signed({1'b0, b_lo});
    assign phi_next = a * b_hi;

    assign sum     = (PW'(phi_reg) <<< LW) + PW'(plo_reg) + RND;
    assign shifted = $signed(sum[PW-1:Q_FRAC]);
    assign p_next  = OW'(shifted);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
        end
        if (en[1])
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

### sv/cpwa_scale.sv
// ----------------------------------------------------------------------------
// cpwa_scale: output pixel coordinate to scaled Q16 working coordinate
// Stage one estimates the rounded quotient by a reciprocal product, stage two
// checks the low remainder bits and adds one where the estimate fell short.
// ----------------------------------------------------------------------------
module cpwa_scale (
    input  logic                      clk,
    input  logic [1:0]                en,
    input  logic [cpwa_pkg::COL_W-1:0] col,
    input  logic [cpwa_pkg::ROW_W-1:0] row,
    output logic [cpwa_pkg::X_W-1:0]   x,
    output logic [cpwa_pkg::Y_W-1:0]   y
);
    import cpwa_pkg::*;

    localparam int XP_W = COL_W + RCP_W;
    localparam int YP_W = ROW_W + RCP_W;

    logic [XP_W-1:0]  xprod;
    logic [YP_W-1:0]  yprod;
    logic [X_W-1:0]   xest_reg;
    logic [Y_W-1:0]   yest_reg;
    logic [REM_W-1:0] xrem;
    logic [REM_W-1:0] yrem;
    logic [X_W-1:0]   x_next;
    logic [Y_W-1:0]   y_next;
    logic [X_W-1:0]   x_reg;
    logic [Y_W-1:0]   y_reg;

    assign xprod = XP_W'(col) * XP_W'(X_RCP) + XP_W'(X_BIAS);
    assign yprod = YP_W'(row) * YP_W'(Y_RCP) + YP_W'(Y_BIAS);

    // The remainder lies below twice the divisor, so its low bits suffice.
    assign xrem   = X_NLO - REM_W'(xest_reg[REM_W-1:0] * X_DIV);
    assign yrem   = Y_NLO - REM_W'(yest_reg[REM_W-1:0] * Y_DIV);
    assign x_next = xest_reg + X_W'(xrem >= X_DIV);
    assign y_next = yest_reg + Y_W'(yrem >= Y_DIV);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            xest_reg <= xprod[XP_W-1:Q_FRAC];
            yest_reg <= yprod[YP_W-1:Q_FRAC];
        end
        if (en[1])
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign x = x_reg;
    assign y = y_reg;

endmodule

### sv/cpwa_mono.sv
// ----------------------------------------------------------------------------
// cpwa_mono: monomials of the scaled coordinates
// Two multiplier passes: the squares and cross product first, then the four
// cubic monomials. Lower-order values are delayed to stay aligned.
// ----------------------------------------------------------------------------
module cpwa_mono (
    input  logic                    clk,
    input  logic [3:0]              en,
    input  logic [cpwa_pkg::X_W-1:0] x,
    input  logic [cpwa_pkg::Y_W-1:0] y,
    output cpwa_pkg::mono_t          mono
);
    import cpwa_pkg::*;

    logic signed [XX_W:0]  xx_p;
    logic signed [XY_W:0]  xy_p;
    logic signed [YY_W:0]  yy_p;
    logic signed [X3_W:0]  x3_p;
    logic signed [X2Y_W:0] x2y_p;
    logic signed [XY2_W:0] xy2_p;
    logic signed [Y3_W:0]  y3_p;

    logic [X_W-1:0]  x_s3_reg, x_s4_reg, x_s5_reg, x_s6_reg;
    logic [Y_W-1:0]  y_s3_reg, y_s4_reg, y_s5_reg, y_s6_reg;
    logic [XX_W-1:0] xx_s5_reg, xx_s6_reg;
    logic [XY_W-1:0] xy_s5_reg, xy_s6_reg;
    logic [YY_W-1:0] yy_s5_reg, yy_s6_reg;

    cpwa_mul #(.AW(X_W + 1), .BW(X_W + 1), .OW(XX_W + 1)) u_xx (
        .clk (clk), .en (en[1:0]),
        .a ($signed({1'b0, x})), .b ($signed({1'b0, x})), .p (xx_p)
    );
    cpwa_mul #(.AW(X_W + 1), .BW(Y_W + 1), .OW(XY_W + 1)) u_xy (
        .clk (clk), .en (en[1:0]),
        .a ($signed({1'b0, x})), .b ($signed({1'b0, y})), .p (xy_p)
    );
    cpwa_mul #(.AW(Y_W + 1), .BW(Y_W + 1), .OW(YY_W + 1)) u_yy (
        .clk (clk), .en (en[1:0]),
        .a ($signed({1'b0, y})), .b ($signed({1'b0, y})), .p (yy_p)
    );

    cpwa_mul #(.AW(X_W + 1), .BW(XX_W + 1), .OW(X3_W + 1)) u_x3 (
        .clk (clk), .en (en[3:2]),
        .a ($signed({1'b0, x_s4_reg})), .b ($signed({1'b0, xx_p[XX_W-1:0]})), .p (x3_p)
    );
    cpwa_mul #(.AW(Y_W + 1), .BW(XX_W + 1), .OW(X2Y_W + 1)) u_x2y (
        .clk (clk), .en (en[3:2]),
        .a ($signed({1'b0, y_s4_reg})), .b ($signed({1'b0, xx_p[XX_W-1:0]})), .p (x2y_p)
    );
    cpwa_mul #(.AW(X_W + 1), .BW(YY_W + 1), .OW(XY2_W + 1)) u_xy2 (
        .clk (clk), .en (en[3:2]),
        .a ($signed({1'b0, x_s4_reg})), .b ($signed({1'b0, yy_p[YY_W-1:0]})), .p (xy2_p)
    );
    cpwa_mul #(.AW(Y_W + 1), .BW(YY_W + 1), .OW(Y3_W + 1)) u_y3 (
        .clk (clk), .en (en[3:2]),
        .a ($signed({1'b0, y_s4_reg})), .b ($signed({1'b0, yy_p[YY_W-1:0]})), .p (y3_p)
    );

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_s3_reg <= x;
            y_s3_reg <= y;
        end
        if (en[1])
        begin
            x_s4_reg <= x_s3_reg;
            y_s4_reg <= y_s3_reg;
        end
        if (en[2])
        begin
            x_s5_reg  <= x_s4_reg;
            y_s5_reg  <= y_s4_reg;
            xx_s5_reg <= xx_p[XX_W-1:0];
            xy_s5_reg <= xy_p[XY_W-1:0];
            yy_s5_reg <= yy_p[YY_W-1:0];
        end
        if (en[3])
        begin
            x_s6_reg  <= x_s5_reg;
            y_s6_reg  <= y_s5_reg;
            xx_s6_reg <= xx_s5_reg;
            xy_s6_reg <= xy_s5_reg;
            yy_s6_reg <= yy_s5_reg;
        end
    end

    assign mono.x   = x_s6_reg;
    assign mono.y   = y_s6_reg;
    assign mono.xx  = xx_s6_reg;
    assign mono.xy  = xy_s6_reg;
    assign mono.yy  = yy_s6_reg;
    assign mono.x3  = x3_p[X3_W-1:0];
    assign mono.x2y = x2y_p[X2Y_W-1:0];
    assign mono.xy2 = xy2_p[XY2_W-1:0];
    assign mono.y3  = y3_p[Y3_W-1:0];

endmodule

### sv/cpwa_poly.sv
// ----------------------------------------------------------------------------
// cpwa_poly: bivariate cubic evaluator
// Nine coefficient products, each rounded to Q40, then a two-stage sum with
// the constant term and the half-unit bias for the final rounding.
// ----------------------------------------------------------------------------
module cpwa_poly #(
    parameter cpwa_pkg::coef_arr_t COEF = cpwa_pkg::COL_COEF
) (
    input  logic                              clk,
    input  logic [3:0]                        en,
    input  cpwa_pkg::mono_t                   mono,
    output logic signed [cpwa_pkg::ACC_W-1:0] acc
);
    import cpwa_pkg::*;

    localparam logic signed [ACC_W-1:0] K0_BIASED = COEF[0] + ACC_HALF;

    logic signed [ACC_W-1:0] t1, t2, t3, t4, t5, t6, t7, t8, t9;
    logic signed [ACC_W-1:0] sa_reg, sb_reg, sc_reg;
    logic signed [ACC_W-1:0] acc_reg;

    cpwa_mul #(.AW(X_W + 1), .BW(LIN_W), .OW(ACC_W)) u_t1 (
        .clk (clk), .en (en[1:0]),
        .a ($signed({1'b0, mono.x})), .b (LIN_W'(COEF[1])), .p (t1)
    );
    cpwa_mul #(.AW(Y_W + 1), .BW(LIN_W), .OW(ACC_W)) u_t2 (
        .clk (clk), .en (en[1:0]),
        .a ($signed({1'b0, mono.y})), .b (LIN_W'(COEF[2])), .p (t2)
    );
    cpwa_mul #(.AW(QUAD_W), .BW(XX_W + 1), .OW(ACC_W)) u_t3 (
        .clk (clk), .en (en[1:0]),
        .a (QUAD_W'(COEF[3])), .b ($signed({1'b0, mono.xx})), .p (t3)
    );
    cpwa_mul #(.AW(QUAD_W), .BW(XY_W + 1), .OW(ACC_W)) u_t4 (
        .clk (clk), .en (en[1:0]),
        .a (QUAD_W'(COEF[4])), .b ($signed({1'b0, mono.xy})), .p (t4)
    );
    cpwa_mul #(.AW(QUAD_W), .BW(YY_W + 1), .OW(ACC_W)) u_t5 (
        .clk (clk), .en (en[1:0]),
        .a (QUAD_W'(COEF[5])), .b ($signed({1'b0, mono.yy})), .p (t5)
    );
    cpwa_mul #(.AW(CUB_W), .BW(X3_W + 1), .OW(ACC_W)) u_t6 (
        .clk (clk), .en (en[1:0]),
        .a (CUB_W'(COEF[6])), .b ($signed({1'b0, mono.x3})), .p (t6)
    );
    cpwa_mul #(.AW(CUB_W), .BW(X2Y_W + 1), .OW(ACC_W)) u_t7 (
        .clk (clk), .en (en[1:0]),
        .a (CUB_W'(COEF[7])), .b ($signed({1'b0, mono.x2y})), .p (t7)
    );
    cpwa_mul #(.AW(CUB_W), .BW(XY2_W + 1), .OW(ACC_W)) u_t8 (
        .clk (clk), .en (en[1:0]),
        .a (CUB_W'(COEF[8])), .b ($signed({1'b0, mono.xy2})), .p (t8)
    );
    cpwa_mul #(.AW(CUB_W), .BW(Y3_W + 1), .OW(ACC_W)) u_t9 (
        .clk (clk), .en (en[1:0]),
        .a (CUB_W'(COEF[9])), .b ($signed({1'b0, mono.y3})), .p (t9)
    );

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            sa_reg <= K0_BIASED + t1 + t2 + t3;
            sb_reg <= t4 + t5 + t6;
            sc_reg <= t7 + t8 + t9;
        end
        if (en[3])
        begin
            acc_reg <= sa_reg + sb_reg + sc_reg;
        end
    end

    assign acc = acc_reg;

endmodule

### sv/cubic_polynomial_warp_address.sv
// Throughput: one word per cycle unless the output stalls; every stage holds
// its own valid bit and advances whenever the stage after it is empty or
// moving, so bubbles close up.
// s_tready follows m_tready through the enable chain in the same cycle, and a
// stalled output holds only the full stages from the output back.
// Reset clears every valid bit and loads source width 6240 and height 1600.
// ----------------------------------------------------------------------------
// cubic_polynomial_warp_address: nearest-neighbor source address generator
// Scales each output coordinate, evaluates two fixed cubics for the source
// column and row, rounds, saturates and checks against the source size.
// ----------------------------------------------------------------------------
module cubic_polynomial_warp_address (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [cpwa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cpwa_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // out_col[13:0], out_row[25:14]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // src_col[15:0], src_row[31:16]
    output logic                           m_tuser    // inside_res
);
    import cpwa_pkg::*;

    logic [NSTG:1]        vld_reg;
    logic [NSTG+1:1]      en;
    logic [CFG_W-1:0]     src_width_reg;
    logic [CFG_W-1:0]     src_height_reg;
    logic [X_W-1:0]       x;
    logic [Y_W-1:0]       y;
    mono_t                mono;
    logic signed [ACC_W-1:0] col_acc;
    logic signed [ACC_W-1:0] row_acc;
    logic [SRC_W-1:0]     col_sat;
    logic [SRC_W-1:0]     row_sat;
    logic                 inside_next;
    logic [SRC_W-1:0]     src_col_reg;
    logic [SRC_W-1:0]     src_row_reg;
    logic                 inside_reg;

    function automatic logic [SRC_W-1:0] sat_src(input logic [RES_W-1:0] v);
        logic [RES_W-SRC_W:0] hi;
        hi = v[RES_W-1:SRC_W-1];
        if (hi == '0 || hi == '1)
            return v[SRC_W-1:0];
        else if (v[RES_W-1])
            return {1'b1, {(SRC_W - 1){1'b0}}};
        else
            return {1'b0, {(SRC_W - 1){1'b1}}};
    endfunction

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SRC_WIDTH_RST;
            src_height_reg <= SRC_HEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SOURCE_WIDTH:  src_width_reg  <= cfg_data;
                REG_SOURCE_HEIGHT: src_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or its word moves on this cycle.
    always_comb
    begin
        en[NSTG+1] = m_tready;
        for (int k = NSTG; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[1])
                vld_reg[1] <= s_tvalid;
            for (int k = 2; k <= NSTG; k++)
            begin
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    assign s_tready = en[1];
    assign m_tvalid = vld_reg[NSTG];

    cpwa_scale u_scale (
        .clk (clk),
        .en  (en[2:1]),
        .col (s_tdata[COL_W-1:0]),
        .row (s_tdata[COL_W+ROW_W-1:COL_W]),
        .x   (x),
        .y   (y)
    );

    cpwa_mono u_mono (
        .clk  (clk),
        .en   (en[6:3]),
        .x    (x),
        .y    (y),
        .mono (mono)
    );

    cpwa_poly #(.COEF(COL_COEF)) u_col_poly (
        .clk  (clk),
        .en   (en[10:7]),
        .mono (mono),
        .acc  (col_acc)
    );

    cpwa_poly #(.COEF(ROW_COEF)) u_row_poly (
        .clk  (clk),
        .en   (en[10:7]),
        .mono (mono),
        .acc  (row_acc)
    );

    // The arithmetic shift of the biased sum is the half-up rounding.
    assign col_sat = sat_src(col_acc[ACC_W-1:ACC_FRAC]);
    assign row_sat = sat_src(row_acc[ACC_W-1:ACC_FRAC]);

    assign inside_next = !col_sat[SRC_W-1] && (col_sat[CFG_W-1:0] < src_width_reg) &&
                         !row_sat[SRC_W-1] && (row_sat[CFG_W-1:0] < src_height_reg);

    always_ff @(posedge clk)
    begin
        if (en[NSTG])
        begin
            src_col_reg <= col_sat;
            src_row_reg <= row_sat;
            inside_reg  <= inside_next;
        end
    end

    assign m_tdata = {src_row_reg, src_col_reg};
    assign m_tuser = inside_reg;

    // A full pipeline with a stalled output must refuse new words.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&vld_reg) && !m_tready |-> !s_tready)
        else $error("input accepted while every stage is full and stalled");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[1])
        else $error("accepted word did not enter the first stage");

    a_bubble_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !vld_reg[NSTG-1] |=> !m_tvalid)
        else $error("output word repeated after it was taken");

    a_inside_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tdata[SRC_W-1] && !m_tdata[2*SRC_W-1])
        else $error("inside flag set for a negative source coordinate");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the cubic warp address generator
// Streams output pixel coordinates into the block with random gaps and
// backpressure, predicts each source address and inside flag in fixed point,
// and compares every output word in order while the source size is varied.
// ----------------------------------------------------------------------------
module testbench;
    import cpwa_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int COL_MAX     = 10455;
    localparam int ROW_MAX     = 2663;
    localparam int COL_TOP     = 2 ** COL_W - 1;
    localparam int ROW_TOP     = 2 ** ROW_W - 1;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } pixel_t;

    typedef struct packed {
        logic signed [SRC_W-1:0] col;
        logic signed [SRC_W-1:0] row;
        logic                    in_image;
    } src_addr_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_SOURCE_WIDTH;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;
    logic                 m_tuser;

    // Source column and row polynomials, signed Q40, in the order
    // 1, X, Y, X^2, XY, Y^2, X^3, X^2Y, XY^2, Y^3.
    logic signed [63:0] col_poly [10] = '{
        64'sd2245642548569702, 64'sd1420239169598, -64'sd30406994066,
        -64'sd4652583, -64'sd12838997, 64'sd20909413,
        64'sd150, 64'sd7909, -64'sd9048, 64'sd3131
    };
    logic signed [63:0] row_poly [10] = '{
        64'sd955849438490788, -64'sd223750616252, 64'sd1210012546367,
        64'sd63494597, 64'sd22668631, 64'sd48644593,
        -64'sd6394, -64'sd8666, 64'sd20035, -64'sd63100
    };

    logic [CFG_W-1:0] src_width  = SRC_WIDTH_RST;
    logic [CFG_W-1:0] src_height = SRC_HEIGHT_RST;

    pixel_t    coord_q [$];
    src_addr_t addr_q [$];
    pixel_t    sent_px;
    src_addr_t exp_addr;
    bit        quiet;
    int        send_idle;
    int        recv_stall;
    int        err_cnt      = 0;
    int        word_cnt     = 0;
    int        outside_cnt  = 0;
    int        settings_cnt = 1;
    int        cycle_cnt    = 0;

    cubic_polynomial_warp_address u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    function automatic logic [127:0] q16_mul(input logic [127:0] a, input logic [127:0] b);
        return (a * b + 128'd32768) >> 16;
    endfunction

    // Works out the source address of one output pixel against the current size.
    function automatic src_addr_t predict_address(input pixel_t px);
        logic [127:0]        mono [10];
        logic signed [127:0] acc;
        logic signed [127:0] kw;
        logic signed [127:0] mw;
        logic signed [127:0] v;
        int                  res [2];
        int                  p;
        int                  i;
        src_addr_t           r;
        mono[0] = 128'd1 << 16;
        mono[1] = ((128'(px.col) * 6239 << 16) + 5227) / 10455;
        mono[2] = ((128'(px.row) * 1599 << 16) + 1331) / 2663;
        mono[3] = q16_mul(mono[1], mono[1]);
        mono[4] = q16_mul(mono[1], mono[2]);
        mono[5] = q16_mul(mono[2], mono[2]);
        mono[6] = q16_mul(mono[3], mono[1]);
        mono[7] = q16_mul(mono[3], mono[2]);
        mono[8] = q16_mul(mono[1], mono[5]);
        mono[9] = q16_mul(mono[5], mono[2]);
        for (p = 0; p < 2; p++)
        begin
            acc = (p == 0) ? col_poly[0] : row_poly[0];
            for (i = 1; i < 10; i++)
            begin
                kw = (p == 0) ? col_poly[i] : row_poly[i];
                mw = mono[i];
                // Arithmetic shift floors, which matches half-up for either sign.
                acc = acc + ((kw * mw + 128'sd32768) >>> 16);
            end
            v = (acc + (128'sd1 <<< 39)) >>> 40;
            if (v > 32767)
                v = 32767;
            else if (v < -32768)
                v = -32768;
            res[p] = int'(v);
        end
        r.col      = SRC_W'(res[0]);
        r.row      = SRC_W'(res[1]);
        r.in_image = (res[0] >= 0) && (res[0] < int'(src_width)) &&
                     (res[1] >= 0) && (res[1] < int'(src_height));
        return r;
    endfunction

    // Mostly back-to-back, sometimes a short gap, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t px;
        int     r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            px.col = COL_W'($urandom_range(0, COL_MAX));
            px.row = ROW_W'($urandom_range(0, ROW_MAX));
        end
        else if (r < 85)
        begin
            px.col = COL_W'($urandom_range(0, COL_TOP));
            px.row = ROW_W'($urandom_range(0, ROW_TOP));
        end
        else if (r < 93)
        begin
            px.col = ($urandom_range(0, 1) != 0) ? COL_W'(COL_MAX) : '0;
            px.row = ROW_W'($urandom_range(0, ROW_MAX));
            if ($urandom_range(0, 1) != 0)
                px.row = ($urandom_range(0, 1) != 0) ? ROW_W'(ROW_MAX) : '0;
        end
        else
        begin
            // Coordinates past the raster edge
            px.col = COL_W'($urandom_range(COL_MAX + 1, COL_TOP));
            px.row = ROW_W'($urandom_range(ROW_MAX + 1, ROW_TOP));
        end
        return px;
    endfunction

    task automatic report_mismatch(input string field, input int expd, input int got);
        $display("ERROR at %0t ns: %s expected %0d, got %0d", $time, field, expd, got);
        err_cnt++;
    endtask

    task automatic push_pixel(input int col, input int row);
        pixel_t px;
        px.col = COL_W'(col);
        px.row = ROW_W'(row);
        coord_q.push_back(px);
    endtask

    task automatic push_random(input int n);
        quiet = ($urandom_range(0, 3) == 0);
        repeat (n) coord_q.push_back(rand_pixel());
    endtask

    task automatic wait_idle();
        while (coord_q.size() != 0 || s_tvalid || addr_q.size() != 0)
            @(posedge clk);
    endtask

    // Both registers change only while nothing is in flight.
    task automatic set_size(input int w, input int h);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SOURCE_WIDTH;
        cfg_data  <= CFG_W'(w);
        @(posedge clk);
        cfg_index <= REG_SOURCE_HEIGHT;
        cfg_data  <= CFG_W'(h);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        src_width  = CFG_W'(w);
        src_height = CFG_W'(h);
        settings_cnt++;
    endtask

    // Input side: presents coordinate words and predicts each accepted one.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            send_idle = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                addr_q.push_back(predict_address(sent_px));
            if (!s_tvalid || s_tready)
            begin
                if (send_idle > 0)
                begin
                    send_idle--;
                    s_tvalid <= 1'b0;
                end
                else if (coord_q.size() > 0)
                begin
                    sent_px = coord_q.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= {6'b0, sent_px.row, sent_px.col};
                    send_idle = pick_gap();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side: random backpressure and in-order compare of every word.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (addr_q.size() == 0)
                begin
                    report_mismatch("unexpected word, src_col", 0, $signed(m_tdata[15:0]));
                end
                else
                begin
                    exp_addr = addr_q.pop_front();
                    if (m_tdata[15:0] !== exp_addr.col)
                        report_mismatch("src_col", exp_addr.col, $signed(m_tdata[15:0]));
                    if (m_tdata[31:16] !== exp_addr.row)
                        report_mismatch("src_row", exp_addr.row, $signed(m_tdata[31:16]));
                    if (m_tuser !== exp_addr.in_image)
                        report_mismatch("inside_res", exp_addr.in_image, m_tuser);
                    word_cnt++;
                    if (!exp_addr.in_image)
                        outside_cnt++;
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                recv_stall = pick_gap();
                m_tready <= (recv_stall == 0);
                if (recv_stall > 0)
                    recv_stall--;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Timed out with %0d words still expected.", addr_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int k;
        quiet = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes, raster corners, past-the-raster words and bit patterns
        push_pixel(0, 0);
        push_pixel(COL_MAX, ROW_MAX);
        push_pixel(COL_TOP, ROW_TOP);
        push_pixel(0, ROW_TOP);
        push_pixel(COL_TOP, 0);
        push_pixel(COL_MAX, 0);
        push_pixel(0, ROW_MAX);
        push_pixel(1, 1);
        push_pixel(COL_MAX + 1, ROW_MAX + 1);
        push_pixel('h2AAA, 'h555);
        push_pixel('h1555, 'hAAA);
        push_pixel(COL_MAX / 2, ROW_MAX / 2);
        push_pixel(6239, 1599);
        wait_idle();
        push_random(150);
        wait_idle();

        // Tiny and empty source images push most pixels outside; larger and random sizes are tried too.
        set_size(1, 1);
        push_pixel(0, 0);
        push_pixel(COL_TOP, ROW_TOP);
        push_random(60);
        wait_idle();
        set_size(16384, 16384);
        push_random(150);
        wait_idle();
        set_size(0, SRC_HEIGHT_RST);
        push_random(60);
        wait_idle();
        set_size(SRC_WIDTH_RST, 0);
        push_random(60);
        wait_idle();
        set_size(2 ** CFG_W - 1, 2 ** CFG_W - 1);
        push_random(100);
        wait_idle();
        set_size(3000, 800);
        push_random(150);
        wait_idle();
        for (k = 0; k < 4; k++)
        begin
            set_size($urandom_range(1, 16384), $urandom_range(1, 16384));
            push_random(80);
            wait_idle();
        end

        repeat (2 * NSTG) @(posedge clk);
        $display("Checked %0d address words over %0d source sizes, %0d of them outside.",
                 word_cnt, settings_cnt, outside_cnt);
        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
